// File: hdl/evdq_pkg.sv
// Package for the event deque: command, status and register codes,
// the stored event layout and default parameter values.
// No dependencies.
package evdq_pkg;

  // Default geometry.
  localparam int EVDQ_DEPTH            = 256;
  localparam int EVDQ_NEAR_FULL_MARGIN = 12;

  // Command codes.
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd0;
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [1:0] CMD_POP        = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NEAR_FULL = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEPER_CTX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_CODE  = 2'd3;

  // Configuration reset values.
  localparam logic [8:0]  HIGH_MARK_RST  = 9'd128;
  localparam logic [8:0]  LOW_MARK_RST   = 9'd85;
  localparam logic [15:0] KEEPER_CTX_RST = 16'd0;
  localparam logic [15:0] WARN_CODE_RST  = 16'd0;

  // One stored event.
  typedef struct packed {
    logic [7:0]  context_tag;
    logic [7:0]  thread_id;
    logic [15:0] event_code;
    logic [15:0] context_id;
    logic [31:0] payload;
  } evdq_entry_t;

  localparam int ENTRY_W = $bits(evdq_entry_t);

endpackage

// File: hdl/evdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module evdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/event_deque_fifo_watermark.sv
// Circular event deque with a fill watermark warning. Depends on evdq_pkg and evdq_ram.
// The block takes one command per clock unless stalled: push at tail, push at head, or pop
// from head. Each accepted transaction gives one result via the input register, then the
// result register with the store read. A warning-inserting push-back holds the input while
// the warning is written, as the event store has a single write port and the warning is
// written at the head in the cycle after the tail write. The user must write configuration
// registers through a plain write port only while the queue is idle; the block leaves it
// unenforced. The event store has no reset; only written entries are ever popped.
module event_deque_fifo_watermark
  import evdq_pkg::*;
#(
  parameter int DEPTH            = EVDQ_DEPTH,
  parameter int NEAR_FULL_MARGIN = EVDQ_NEAR_FULL_MARGIN
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Command channel.
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             cmd_i,
  input  logic [15:0]            context_id_i,
  input  logic signed [15:0]     event_code_i,
  input  logic [31:0]            payload_i,
  input  logic [7:0]             thread_id_i,
  input  logic signed [7:0]      context_tag_i,
  // Result channel.
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [7:0]             position_o,
  output logic                   warning_inserted_o,
  output logic [8:0]             fill_level_o,
  output logic [15:0]            out_context_id_o,
  output logic signed [15:0]     out_event_code_o,
  output logic [31:0]            out_payload_o,
  output logic [7:0]             out_thread_id_o,
  output logic signed [7:0]      out_context_tag_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = CW + 8;
  localparam int MW  = CW + 9;
  localparam int PXW = AW + 8;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] idx);
    return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
  endfunction

  // Configuration registers.
  logic [8:0]  high_mark_q;
  logic [8:0]  low_mark_q;
  logic [15:0] keeper_ctx_q;
  logic [15:0] warn_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_mark_q  <= HIGH_MARK_RST;
      low_mark_q   <= LOW_MARK_RST;
      keeper_ctx_q <= KEEPER_CTX_RST;
      warn_code_q  <= WARN_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HIGH_MARK:  high_mark_q  <= cfg_data_i[8:0];
        CFG_LOW_MARK:   low_mark_q   <= cfg_data_i[8:0];
        CFG_KEEPER_CTX: keeper_ctx_q <= cfg_data_i;
        CFG_WARN_CODE:  warn_code_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic v0_q, v1_q;
  logic wpend_q;
  logic adv1, fire0, take_in;

  assign adv1       = !v1_q || !out_stall_i;
  assign fire0      = v0_q && adv1 && !wpend_q;
  assign in_stall_o = v0_q && !fire0;
  assign take_in    = in_valid_i && !in_stall_o;

  // Input register.
  logic [1:0]  cmd0_q;
  evdq_entry_t ent0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (take_in) begin
      v0_q <= 1'b1;
    end else if (fire0) begin
      v0_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      cmd0_q             <= cmd_i;
      ent0_q.context_id  <= context_id_i;
      ent0_q.event_code  <= event_code_i;
      ent0_q.payload     <= payload_i;
      ent0_q.thread_id   <= thread_id_i;
      ent0_q.context_tag <= context_tag_i;
    end
  end

  // Queue state.
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          armed_q, armed_d;

  // Command decision.
  logic          warn_c, near_c, noroom_c, warned_c, pop_ok_c;
  logic [1:0]    status_c;
  logic [AW-1:0] pos_idx_c;
  logic          pos_en_c;
  logic          wr_c, rd_c;
  logic [AW-1:0] waddr_c;

  assign warn_c   = armed_q && (MW'(fill_q) > MW'(high_mark_q));
  assign near_c   = (SW'(fill_q) + SW'(NEAR_FULL_MARGIN)) > SW'(DEPTH);
  assign noroom_c = (SW'(fill_q) + (warn_c ? SW'(2) : SW'(1))) > SW'(DEPTH);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    armed_d   = armed_q;
    status_c  = ST_OK;
    warned_c  = 1'b0;
    pop_ok_c  = 1'b0;
    pos_idx_c = '0;
    pos_en_c  = 1'b0;
    wr_c      = 1'b0;
    rd_c      = 1'b0;
    waddr_c   = tail_q;
    unique case (cmd0_q)
      CMD_PUSH_BACK: begin
        priority if (near_c) begin
          status_c = ST_NEAR_FULL;
        end else if (noroom_c) begin
          status_c = ST_FULL;
        end else begin
          if (warn_c) begin
            head_d   = idx_prev(head_q);
            armed_d  = 1'b0;
            warned_c = 1'b1;
          end
          wr_c      = 1'b1;
          waddr_c   = tail_q;
          tail_d    = idx_next(tail_q);
          fill_d    = fill_q + (warn_c ? CW'(2) : CW'(1));
          pos_idx_c = idx_next(tail_q);
          pos_en_c  = 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (fill_q >= CW'(DEPTH)) begin
          status_c = ST_FULL;
        end else begin
          head_d    = idx_prev(head_q);
          wr_c      = 1'b1;
          waddr_c   = idx_prev(head_q);
          fill_d    = fill_q + CW'(1);
          pos_idx_c = idx_prev(head_q);
          pos_en_c  = 1'b1;
        end
      end
      CMD_POP: begin
        if (fill_q == '0) begin
          status_c = ST_EMPTY;
        end else begin
          if (!armed_q && (MW'(fill_q) < MW'(low_mark_q))) begin
            armed_d = 1'b1;
          end
          rd_c     = 1'b1;
          pop_ok_c = 1'b1;
          head_d   = idx_next(head_q);
          fill_d   = fill_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      armed_q <= 1'b1;
    end else if (fire0) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      armed_q <= armed_d;
    end
  end

  // Deferred warning write at the new head, in the cycle after the tail write.
  logic [AW-1:0] wpend_addr_q;
  logic [15:0]   wpend_ctx_q;
  logic [15:0]   wpend_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpend_q <= 1'b0;
    end else begin
      wpend_q <= fire0 && warned_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire0 && warned_c) begin
      wpend_addr_q <= head_d;
      wpend_ctx_q  <= keeper_ctx_q;
      wpend_code_q <= warn_code_q;
    end
  end

  // Event store.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  evdq_entry_t   ram_wdata;
  evdq_entry_t   warn_ent;
  logic [ENTRY_W-1:0] ram_rdata;
  evdq_entry_t   rd_ent;

  always_comb begin
    warn_ent             = '0;
    warn_ent.context_id  = wpend_ctx_q;
    warn_ent.event_code  = wpend_code_q;
  end

  assign ram_we    = wpend_q || (fire0 && wr_c);
  assign ram_waddr = wpend_q ? wpend_addr_q : waddr_c;
  assign ram_wdata = wpend_q ? warn_ent : ent0_q;

  evdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (fire0 && rd_c),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign rd_ent = evdq_entry_t'(ram_rdata);

  // Result register.
  logic [PXW-1:0] pos_ext;
  logic [MW-1:0]  fill_ext;
  logic [1:0]     st1_q;
  logic [7:0]     pos1_q;
  logic           warn1_q;
  logic [8:0]     fill1_q;
  logic           pop1_q;

  assign pos_ext  = pos_en_c ? PXW'(pos_idx_c) : '0;
  assign fill_ext = MW'(fill_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (fire0) begin
      v1_q <= 1'b1;
    end else if (!out_stall_i) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire0) begin
      st1_q   <= status_c;
      pos1_q  <= pos_ext[7:0];
      warn1_q <= warned_c;
      fill1_q <= fill_ext[8:0];
      pop1_q  <= pop_ok_c;
    end
  end

  // Result outputs; popped fields read zero unless a pop succeeded.
  assign out_valid_o        = v1_q;
  assign status_o           = st1_q;
  assign position_o         = pos1_q;
  assign warning_inserted_o = warn1_q;
  assign fill_level_o       = fill1_q;
  assign out_context_id_o   = pop1_q ? rd_ent.context_id  : '0;
  assign out_event_code_o   = pop1_q ? rd_ent.event_code  : '0;
  assign out_payload_o      = pop1_q ? rd_ent.payload     : '0;
  assign out_thread_id_o    = pop1_q ? rd_ent.thread_id   : '0;
  assign out_context_tag_o  = pop1_q ? rd_ent.context_tag : '0;

endmodule

// File: dv/tb_event_deque_fifo_watermark.sv
// Self-checking testbench for event_deque_fifo_watermark: a directed table, then random phases
// under several watermark settings, checked against fixed results or an in-bench deque model.
// Depends on evdq_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_event_deque_fifo_watermark;
  import evdq_pkg::*;

  localparam int           DEPTH         = EVDQ_DEPTH;
  localparam int           MARGIN        = EVDQ_NEAR_FULL_MARGIN;
  localparam logic [1:0]   CMD_UNUSED    = 2'd3;
  localparam int           PHASES        = 7;
  localparam int           PHASE_ITEMS   = 250;
  localparam int           SETTLE_CYCLES = 4;
  localparam int           DRAIN_CYCLES  = 10;
  localparam int           CYCLE_LIMIT   = 500000;

  // One command transaction and one result transaction, at the port widths.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] context_id;
    logic [15:0] event_code;
    logic [31:0] payload;
    logic [7:0]  thread_id;
    logic [7:0]  context_tag;
  } deque_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  position;
    logic        warning_inserted;
    logic [8:0]  fill_level;
    logic [15:0] out_context_id;
    logic [15:0] out_event_code;
    logic [31:0] out_payload;
    logic [7:0]  out_thread_id;
    logic [7:0]  out_context_tag;
  } deque_result_t;

  typedef enum {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    deque_cmd_t            c;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                    typed;
    deque_result_t         want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall_o;
  logic [1:0]            cmd;
  logic [15:0]           context_id;
  logic signed [15:0]    event_code;
  logic [31:0]           payload;
  logic [7:0]            thread_id;
  logic signed [7:0]     context_tag;
  logic                  out_valid_o;
  logic                  out_stall;
  logic [1:0]            status_o;
  logic [7:0]            position_o;
  logic                  warning_inserted_o;
  logic [8:0]            fill_level_o;
  logic [15:0]           out_context_id_o;
  logic signed [15:0]    out_event_code_o;
  logic [31:0]           out_payload_o;
  logic [7:0]            out_thread_id_o;
  logic signed [7:0]     out_context_tag_o;

  // Model of the deque: event store, pointers, fill count, warning arm and registers.
  evdq_entry_t           slots [DEPTH];
  logic [7:0]            head_ptr;
  logic [7:0]            tail_ptr;
  logic [8:0]            queued;
  logic                  armed;
  logic [8:0]            high_mark;
  logic [8:0]            low_mark;
  logic [15:0]           keeper_ctx;
  logic [15:0]           warn_code;

  deque_result_t         pending_results [$];
  dir_row_t              dir_rows [$];

  int                    errors;
  int                    checked;
  int                    cycle_count;
  int                    warn_inserts;
  int                    near_full_rejects;
  int                    full_rejects;
  int                    empty_pops;
  int                    stall_left;
  int                    stall_pct;
  int                    gap_pct;
  bit                    calm;

  event_deque_fifo_watermark dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd),
    .context_id_i       (context_id),
    .event_code_i       (event_code),
    .payload_i          (payload),
    .thread_id_i        (thread_id),
    .context_tag_i      (context_tag),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .status_o           (status_o),
    .position_o         (position_o),
    .warning_inserted_o (warning_inserted_o),
    .fill_level_o       (fill_level_o),
    .out_context_id_o   (out_context_id_o),
    .out_event_code_o   (out_event_code_o),
    .out_payload_o      (out_payload_o),
    .out_thread_id_o    (out_thread_id_o),
    .out_context_tag_o  (out_context_tag_o)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic deque_cmd_t mk_cmd(logic [1:0] op, logic [15:0] ctx, logic [15:0] code,
                                        logic [31:0] pay, logic [7:0] thr, logic [7:0] tag);
    deque_cmd_t c;
    c.cmd         = op;
    c.context_id  = ctx;
    c.event_code  = code;
    c.payload     = pay;
    c.thread_id   = thr;
    c.context_tag = tag;
    return c;
  endfunction

  function automatic deque_result_t plain_result(logic [1:0] st, logic [7:0] pos,
                                                 logic [8:0] lvl);
    deque_result_t r;
    r            = '0;
    r.status     = st;
    r.position   = pos;
    r.fill_level = lvl;
    return r;
  endfunction

  // Applies one command to the deque model and returns the result it must produce.
  function automatic deque_result_t deque_step(deque_cmd_t c);
    deque_result_t r;
    evdq_entry_t   e;
    evdq_entry_t   warn_ev;
    logic          warn;
    int            need;
    r                 = '0;
    e.context_tag     = c.context_tag;
    e.thread_id       = c.thread_id;
    e.event_code      = c.event_code;
    e.context_id      = c.context_id;
    e.payload         = c.payload;
    warn_ev           = '0;
    warn_ev.context_id = keeper_ctx;
    warn_ev.event_code = warn_code;
    case (c.cmd)
      CMD_PUSH_BACK: begin
        warn = armed && (queued > high_mark);
        need = warn ? 2 : 1;
        if (queued + MARGIN > DEPTH) begin
          r.status = ST_NEAR_FULL;
        end else if (queued + need > DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // The warning goes in at the head, the event at the tail.
          if (warn) begin
            head_ptr           = head_ptr - 8'd1;
            slots[head_ptr]    = warn_ev;
            armed              = 1'b0;
            r.warning_inserted = 1'b1;
          end
          slots[tail_ptr] = e;
          tail_ptr        = tail_ptr + 8'd1;
          queued          = queued + 9'(need);
          r.position      = tail_ptr;
        end
      end
      CMD_PUSH_FRONT: begin
        if (queued >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_ptr        = head_ptr - 8'd1;
          slots[head_ptr] = e;
          queued          = queued + 9'd1;
          r.position      = head_ptr;
        end
      end
      CMD_POP: begin
        if (queued == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // The re-arm test sees the fill level before this pop.
          if (!armed && queued < low_mark) armed = 1'b1;
          r.out_context_id  = slots[head_ptr].context_id;
          r.out_event_code  = slots[head_ptr].event_code;
          r.out_payload     = slots[head_ptr].payload;
          r.out_thread_id   = slots[head_ptr].thread_id;
          r.out_context_tag = slots[head_ptr].context_tag;
          head_ptr          = head_ptr + 8'd1;
          queued            = queued - 9'd1;
        end
      end
      default: begin
      end
    endcase
    r.fill_level = queued;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Drives one command transaction and records its expected result once accepted.
  task automatic send_cmd(input deque_cmd_t c, input bit typed, input deque_result_t want);
    deque_result_t r;
    @(negedge clk_i);
    in_valid    <= 1'b1;
    cmd         <= c.cmd;
    context_id  <= c.context_id;
    event_code  <= c.event_code;
    payload     <= c.payload;
    thread_id   <= c.thread_id;
    context_tag <= c.context_tag;
    do @(posedge clk_i); while (in_stall_o);
    r = deque_step(c);
    if (r.warning_inserted) warn_inserts++;
    if (c.cmd != CMD_UNUSED) begin
      case (r.status)
        ST_NEAR_FULL: near_full_rejects++;
        ST_FULL:      full_rejects++;
        ST_EMPTY:     empty_pops++;
        default: begin
        end
      endcase
    end
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk_i);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_HIGH_MARK:  high_mark  = val[8:0];
      CFG_LOW_MARK:   low_mark   = val[8:0];
      CFG_KEEPER_CTX: keeper_ctx = val;
      CFG_WARN_CODE:  warn_code  = val;
      default: begin
      end
    endcase
  endtask

  task automatic add_cmd(input deque_cmd_t c, input bit typed, input deque_result_t want);
    dir_row_t row;
    row.kind    = ROW_CMD;
    row.c       = c;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.typed   = typed;
    row.want    = want;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row.kind    = ROW_CFG;
    row.c       = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    row.typed   = 1'b0;
    row.want    = '0;
    dir_rows.push_back(row);
  endtask

  // Result side: stall in random bursts unless the run is in its calm stretch.
  always @(negedge clk_i) begin
    if (calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(14);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result transaction with no expectation waiting", $time);
      end else begin
        want = pending_results.pop_front();
        checked++;
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("position", 32'(want.position), 32'(position_o));
        check_field("warning_inserted", 32'(want.warning_inserted), 32'(warning_inserted_o));
        check_field("fill_level", 32'(want.fill_level), 32'(fill_level_o));
        check_field("out_context_id", 32'(want.out_context_id), 32'(out_context_id_o));
        check_field("out_event_code", 32'(want.out_event_code),
                    32'($unsigned(out_event_code_o)));
        check_field("out_payload", want.out_payload, out_payload_o);
        check_field("out_thread_id", 32'(want.out_thread_id), 32'(out_thread_id_o));
        check_field("out_context_tag", 32'(want.out_context_tag),
                    32'($unsigned(out_context_tag_o)));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    logic [8:0]  hi;
    logic [8:0]  lo;
    logic [15:0] kc;
    logic [15:0] wc;
    logic [1:0]  op;
    int          push_pct;
    int          pick;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    cmd         = '0;
    context_id  = '0;
    event_code  = '0;
    payload     = '0;
    thread_id   = '0;
    context_tag = '0;
    out_stall   = 1'b0;
    stall_left  = 0;
    stall_pct   = 10;
    gap_pct     = 10;
    calm        = 1'b0;
    errors      = 0;
    checked     = 0;
    cycle_count = 0;
    warn_inserts      = 0;
    near_full_rejects = 0;
    full_rejects      = 0;
    empty_pops        = 0;
    head_ptr    = '0;
    tail_ptr    = '0;
    queued      = '0;
    armed       = 1'b1;
    high_mark   = HIGH_MARK_RST;
    low_mark    = LOW_MARK_RST;
    keeper_ctx  = KEEPER_CTX_RST;
    warn_code   = WARN_CODE_RST;

    // Directed rows: reset state, field extremes, then a warning insert and a re-arm.
    add_cmd(mk_cmd(CMD_POP, 0, 0, 0, 0, 0), 1'b1, plain_result(ST_EMPTY, 0, 0));
    add_cmd(mk_cmd(CMD_UNUSED, 16'h1234, 16'h5678, 32'h9ABC_DEF0, 8'h11, 8'h22), 1'b1,
            plain_result(ST_OK, 0, 0));
    add_cmd(mk_cmd(CMD_PUSH_BACK, 0, 0, 0, 0, 0), 1'b1, plain_result(ST_OK, 1, 1));
    add_cmd(mk_cmd(CMD_PUSH_FRONT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF), 1'b1,
            plain_result(ST_OK, 255, 2));
    add_cmd(mk_cmd(CMD_PUSH_BACK, 16'h8000, 16'h8000, 32'h8000_0000, 8'h80, 8'h80), 1'b1,
            plain_result(ST_OK, 2, 3));
    add_cmd(mk_cmd(CMD_PUSH_FRONT, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 8'h7F, 8'h7F), 1'b1,
            plain_result(ST_OK, 254, 4));
    repeat (4) add_cmd(mk_cmd(CMD_POP, 0, 0, 0, 0, 0), 1'b0, '0);
    add_cmd(mk_cmd(CMD_POP, 0, 0, 0, 0, 0), 1'b1, plain_result(ST_EMPTY, 0, 0));
    add_cfg(CFG_HIGH_MARK, 16'd2);
    add_cfg(CFG_LOW_MARK, 16'd5);
    add_cfg(CFG_KEEPER_CTX, 16'hFFFF);
    add_cfg(CFG_WARN_CODE, 16'h8000);
    for (int i = 0; i < 5; i++) begin
      add_cmd(mk_cmd(CMD_PUSH_BACK, 16'(16'h0100 + i), 16'(16'hA000 + i), 32'hC0DE_0000 + i,
                     8'(i), 8'(8'hF0 + i)),
              1'b0, '0);
    end
    repeat (3) add_cmd(mk_cmd(CMD_POP, 0, 0, 0, 0, 0), 1'b0, '0);
    add_cmd(mk_cmd(CMD_PUSH_BACK, 16'h5A5A, 16'hA5A5, 32'h5A5A_A5A5, 8'h5A, 8'hA5), 1'b0, '0);
    add_cmd(mk_cmd(CMD_PUSH_FRONT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF), 1'b0, '0);

    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: each sets the watermarks, then runs a biased mix of commands.
    for (int ph = 0; ph < PHASES; ph++) begin
      kc = 16'($urandom);
      wc = 16'($urandom);
      case (ph)
        0: begin hi = 128; lo = 85;  push_pct = 90; end
        1: begin hi = 200; lo = 0;   kc = 16'hFFFF; wc = 16'h7FFF; push_pct = 85; end
        2: begin hi = 0;   lo = 256; kc = 16'h0000; wc = 16'h8000; push_pct = 12; end
        3: begin hi = 256; lo = 85;  push_pct = 55; end
        5: begin hi = 16;  lo = 8;   push_pct = 45; end
        default: begin
          hi       = 9'($urandom_range(256));
          lo       = 9'($urandom_range(256));
          push_pct = (ph == 4) ? 70 : 30;
        end
      endcase
      settle();
      write_reg(CFG_HIGH_MARK, 16'(hi));
      write_reg(CFG_LOW_MARK, 16'(lo));
      write_reg(CFG_KEEPER_CTX, kc);
      write_reg(CFG_WARN_CODE, wc);
      gap_pct   = ((ph + 1) % 3) * 12;
      stall_pct = (ph % 3) * 12;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == PHASES - 1 && n == PHASE_ITEMS / 2) calm = 1'b1;
        if (ph == 3 && n == PHASE_ITEMS / 2) settle();
        if (!calm && $urandom_range(99) < gap_pct) hold_off($urandom_range(1, 15));
        pick = $urandom_range(99);
        if (pick < 2) begin
          op = CMD_UNUSED;
        end else if (pick < push_pct) begin
          op = ($urandom_range(99) < 35) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else begin
          op = CMD_POP;
        end
        send_cmd(mk_cmd(op, 16'($urandom), 16'($urandom), $urandom, 8'($urandom),
                        8'($urandom)), 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d result transactions: %0d directed rows, %0d random phases.",
             checked, dir_rows.size(), PHASES);
    $display("Seen %0d warning inserts, %0d near-full and %0d full rejections, %0d empty pops.",
             warn_inserts, near_full_rejects, full_rejects, empty_pops);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
